// ----- sv/pbta_pkg.sv -----
//------------------------------------------------------------------------------
// pbta_pkg
// Shared types, op codes and lane helpers of the packed byte tuple ALU.
//------------------------------------------------------------------------------
`default_nettype none

package pbta_pkg;

  localparam int LANES   = 8;
  localparam int LEN_W   = 4;
  localparam int VEC_W   = 8 * LANES;
  localparam int LIDX_W  = $clog2(LANES);
  localparam int BYTE_MAX = 255;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_REM  = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_XOR  = 4'd7,
    OP_NOT  = 4'd8,
    OP_REV  = 4'd9,
    OP_CMP  = 4'd10
  } op_t;

  localparam logic [1:0] CMP_EQ_LEN = 2'd0;
  localparam logic [1:0] CMP_EQ     = 2'd1;
  localparam logic [1:0] CMP_GE     = 2'd2;
  localparam logic [1:0] CMP_GT     = 2'd3;

  // Per-lane result handed to the merge stage
  typedef struct packed {
    logic [7:0] val;
    logic       dz;
    logic [1:0] cmp;   // 01 a>b, 10 a<b, 00 equal
  } lane_res_t;

  // Saturate a length field to LANES
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] l);
    sat_len = (l > LEN_W'(LANES)) ? LEN_W'(LANES) : l;
  endfunction

  // Clamp a signed 41-bit value to 0..255
  function automatic logic [7:0] clamp41(input logic signed [40:0] v);
    if (v < 0) clamp41 = 8'd0;
    else if (v > 41'sd255) clamp41 = 8'(BYTE_MAX);
    else clamp41 = v[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/pbta_lane.sv -----
//------------------------------------------------------------------------------
// pbta_lane
// One byte lane: add, sub, mul, div, rem and bitwise ops with clamping, plus
// the lane-level compare result. Division runs as a pipeline of 8 stages
// (dividend magnitude is at most 255), followed by an output register.
//------------------------------------------------------------------------------
`default_nettype none

module pbta_lane
  import pbta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [3:0]        op,
  input  wire logic [7:0]        x,
  input  wire logic signed [32:0] y,
  input  wire logic              active,
  output lane_res_t              res
);

  localparam int STG = 8;

  // Stage 0 registers: operands and quick results
  logic [3:0]         op_s [STG+1];
  logic               act_s [STG+1];
  logic               yneg_s [STG+1];
  logic               yz_s [STG+1];
  logic [7:0]         fast_s [STG+1];
  logic [1:0]         cmp_s [STG+1];
  logic [32:0]        ymag_s [STG+1];
  logic [7:0]         q_s [STG+1];
  logic [7:0]         r_s [STG+1];   // remainder so far (< ymag, <= 255)
  logic [7:0]         xs_s [STG+1];  // remaining dividend bits

  logic signed [40:0] sum;
  logic signed [40:0] dif;
  logic signed [40:0] prd;
  logic [63:0]        yext;
  logic [63:0]        bw;
  logic [7:0]         fast;
  logic [1:0]         cmp;

  // Compute the quick (non-division) lane results and the compare result
  always_comb begin
    sum  = 41'(signed'({1'b0, x})) + 41'(y);
    dif  = 41'(signed'({1'b0, x})) - 41'(y);
    prd  = 41'(signed'({1'b0, x})) * 41'(y);
    yext = 64'(y);
    case (op)
      OP_AND:  bw = {56'd0, x} & yext;
      OP_OR:   bw = {56'd0, x} | yext;
      default: bw = {56'd0, x} ^ yext;
    endcase
    if (bw[63]) fast = 8'd0;
    else if (bw > 64'd255) fast = 8'(BYTE_MAX);
    else fast = bw[7:0];
    case (op)
      OP_ADD:  fast = clamp41(sum);
      OP_SUB:  fast = clamp41(dif);
      OP_MUL:  fast = clamp41(prd);
      default: ;
    endcase
    if (41'(signed'({1'b0, x})) > 41'(y)) cmp = 2'b01;
    else if (41'(signed'({1'b0, x})) < 41'(y)) cmp = 2'b10;
    else cmp = 2'b00;
  end

  // Capture the lane inputs
  always_ff @(posedge clk) begin
    op_s[0]   <= op;
    act_s[0]  <= active;
    yneg_s[0] <= y[32];
    yz_s[0]   <= (y == '0);
    fast_s[0] <= fast;
    cmp_s[0]  <= cmp;
    ymag_s[0] <= y[32] ? 33'(-y) : 33'(y);
    q_s[0]    <= '0;
    r_s[0]    <= '0;
    xs_s[0]   <= x;
  end

  // Advance one restoring division step per stage
  for (genvar k = 0; k < STG; k++) begin : g_div
    logic [32:0] trial;
    logic        ge;
    always_comb begin
      trial = {24'd0, r_s[k], xs_s[k][7]};
      ge    = trial >= ymag_s[k];
    end
    always_ff @(posedge clk) begin
      op_s[k+1]   <= op_s[k];
      act_s[k+1]  <= act_s[k];
      yneg_s[k+1] <= yneg_s[k];
      yz_s[k+1]   <= yz_s[k];
      fast_s[k+1] <= fast_s[k];
      cmp_s[k+1]  <= cmp_s[k];
      ymag_s[k+1] <= ymag_s[k];
      xs_s[k+1]   <= {xs_s[k][6:0], 1'b0};
      q_s[k+1]    <= {q_s[k][6:0], ge};
      r_s[k+1]    <= ge ? 8'(trial - ymag_s[k]) : trial[7:0];
    end
  end

  // Select the lane result; quotient sign follows the divisor
  always_ff @(posedge clk) begin
    res.cmp <= cmp_s[STG];
    res.dz  <= act_s[STG] && yz_s[STG] &&
               (op_s[STG] == OP_DIV || op_s[STG] == OP_REM);
    if (!act_s[STG]) res.val <= '0;
    else if (op_s[STG] == OP_DIV)
      res.val <= (yneg_s[STG] && q_s[STG] != 8'd0) ? 8'd0 : q_s[STG];
    else if (op_s[STG] == OP_REM) res.val <= r_s[STG];
    else res.val <= fast_s[STG];
  end

endmodule

`default_nettype wire

// ----- sv/pbta_merge.sv -----
//------------------------------------------------------------------------------
// pbta_merge
// Combines the lane results into the output vector, length and flags, and
// handles complement, reverse, compare and pass-through.
//------------------------------------------------------------------------------
`default_nettype none

module pbta_merge
  import pbta_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [3:0]       op,
  input  wire logic [VEC_W-1:0] va,
  input  wire logic [LEN_W-1:0] la,
  input  wire logic [LEN_W-1:0] lb,
  input  wire logic [LEN_W-1:0] n,
  input  wire logic [LEN_W-1:0] m,
  input  wire logic [1:0]       mode,
  input  lane_res_t             lr [LANES],
  output logic [VEC_W-1:0]      vec_out,
  output logic [LEN_W-1:0]      len_out,
  output logic                  truth,
  output logic                  div_zero
);

  logic [VEC_W-1:0] v;
  logic [VEC_W-1:0] rv;
  logic [LEN_W-1:0] l;
  logic             dz;
  logic             t;
  logic [1:0]       c;

  always_comb begin
    dz = 1'b0;
    c  = 2'b00;
    for (int i = 0; i < LANES; i++) begin
      dz = dz | lr[i].dz;
      if (c == 2'b00 && LEN_W'(i) < n) c = lr[i].cmp;
    end
    // Reverse the first m lanes
    rv = va;
    for (int i = 0; i < LANES; i++)
      if (LEN_W'(i) < m) rv[8*i +: 8] = va[8*(32'(m)-1-i) +: 8];
    case (mode)
      CMP_EQ_LEN: t = (c == 2'b00) && (la == lb);
      CMP_EQ:     t = (c == 2'b00);
      CMP_GE:     t = (c != 2'b10);
      default:    t = (c == 2'b01);
    endcase
    v = va;
    l = la;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR: begin
        if (!dz) begin
          for (int i = 0; i < LANES; i++) v[8*i +: 8] = lr[i].val;
          l = n;
        end
      end
      OP_NOT: begin
        for (int i = 0; i < LANES; i++)
          if (LEN_W'(i) < la) v[8*i +: 8] = ~va[8*i +: 8];
      end
      OP_REV: v = rv;
      OP_CMP: begin
        v = '0;
        l = '0;
      end
      default: ;
    endcase
  end

  // Register the merged result
  always_ff @(posedge clk) begin
    vec_out  <= v;
    len_out  <= l;
    truth    <= (op == OP_CMP) ? t : 1'b0;
    div_zero <= (op == OP_DIV || op == OP_REM) ? dz : 1'b0;
  end

endmodule

`default_nettype wire

// ----- sv/packed_byte_tuple_alu.sv -----
//------------------------------------------------------------------------------
// packed_byte_tuple_alu
// Saturating packed byte-vector ALU with one lane unit per byte.
//------------------------------------------------------------------------------
// Usage: drive the operand ports and pulse start; busy is always low, so an
// operation is transferred on every cycle that start is high. Each transfer
// produces exactly one result: vec_out, len_out, truth and div_zero are valid
// for one cycle while done is high, once the transfer has passed the input
// register, the lane operand register, 8 pipelined division steps in each
// lane, the lane output register and the merge register. Throughput is one
// operation per cycle; the lane pipelines set the latency. No state is kept
// between operations.
// Reset clears the done pipeline; results of operations in flight are
// dropped. The receiver cannot stall, so results are never held.
//------------------------------------------------------------------------------
`default_nettype none

module packed_byte_tuple_alu
  import pbta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [3:0]        op,
  input  wire logic [VEC_W-1:0]  vec_a,
  input  wire logic [LEN_W-1:0]  len_a,
  input  wire logic [VEC_W-1:0]  vec_b,
  input  wire logic [LEN_W-1:0]  len_b,
  input  wire logic              use_vector,
  input  wire logic signed [31:0] scalar,
  input  wire logic              use_part,
  input  wire logic [LEN_W-1:0]  part_len,
  input  wire logic [1:0]        cmp_mode,
  output logic                   done,
  output logic [VEC_W-1:0]       vec_out,
  output logic [LEN_W-1:0]       len_out,
  output logic                   truth,
  output logic                   div_zero
);

  localparam int LAT = 12;
  localparam int DLY = 10;   // merge side inputs aligned with lane output

  logic [LEN_W-1:0] la, lb, pl, n, m;
  logic [VEC_W-1:0] va, vb;
  logic [LAT-1:0]   vld;
  lane_res_t        lr [LANES];

  // Merge-side operand delay line
  logic [3:0]       op_d [DLY];
  logic [VEC_W-1:0] va_d [DLY];
  logic [LEN_W-1:0] la_d [DLY], lb_d [DLY], n_d [DLY], m_d [DLY];
  logic [1:0]       md_d [DLY];

  assign busy = 1'b0;

  // Saturate lengths, mask operands to their active lanes, pick n and m
  always_comb begin
    la = sat_len(len_a);
    lb = sat_len(len_b);
    pl = sat_len(part_len);
    for (int i = 0; i < LANES; i++) begin
      va[8*i +: 8] = (LEN_W'(i) < la) ? vec_a[8*i +: 8] : 8'd0;
      vb[8*i +: 8] = (LEN_W'(i) < lb) ? vec_b[8*i +: 8] : 8'd0;
    end
    n = (use_vector && lb > la) ? lb : la;
    m = (use_part && pl < la) ? pl : la;
  end

  // Register the transferred operation for the lanes
  logic [3:0]        op_r;
  logic [VEC_W-1:0]  va_r, vb_r;
  logic [LEN_W-1:0]  la_r, lb_r, n_r, m_r, na_r;
  logic              usev_r;
  logic signed [31:0] sc_r;
  logic [1:0]        md_r;

  always_ff @(posedge clk) begin
    op_r   <= op;
    va_r   <= va;
    vb_r   <= vb;
    la_r   <= la;
    lb_r   <= lb;
    n_r    <= (op == OP_CMP) ? ((lb > la) ? lb : la) : n;
    na_r   <= n;
    m_r    <= m;
    usev_r <= use_vector;
    sc_r   <= scalar;
    md_r   <= cmp_mode;
  end

  // Lane units
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [32:0] y;
    logic               act;
    logic [3:0]         lop;
    always_comb begin
      if (op_r == OP_CMP) begin
        y   = 33'(signed'({1'b0, vb_r[8*i +: 8]}));
        act = 1'b0;
        lop = op_r;
      end else begin
        y   = usev_r ? 33'(signed'({1'b0, vb_r[8*i +: 8]})) : 33'(sc_r);
        act = (LEN_W'(i) < na_r);
        lop = op_r;
      end
    end
    pbta_lane u_lane (
      .clk    (clk),
      .op     (lop),
      .x      (va_r[8*i +: 8]),
      .y      (y),
      .active (act),
      .res    (lr[i])
    );
  end

  // Delay merge-side operands to meet the lane results
  always_ff @(posedge clk) begin
    op_d[0] <= op_r;
    va_d[0] <= va_r;
    la_d[0] <= la_r;
    lb_d[0] <= lb_r;
    n_d[0]  <= n_r;
    m_d[0]  <= m_r;
    md_d[0] <= md_r;
    for (int k = 1; k < DLY; k++) begin
      op_d[k] <= op_d[k-1];
      va_d[k] <= va_d[k-1];
      la_d[k] <= la_d[k-1];
      lb_d[k] <= lb_d[k-1];
      n_d[k]  <= n_d[k-1];
      m_d[k]  <= m_d[k-1];
      md_d[k] <= md_d[k-1];
    end
  end

  pbta_merge u_merge (
    .clk      (clk),
    .op       (op_d[DLY-1]),
    .va       (va_d[DLY-1]),
    .la       (la_d[DLY-1]),
    .lb       (lb_d[DLY-1]),
    .n        (n_d[DLY-1]),
    .m        (m_d[DLY-1]),
    .mode     (md_d[DLY-1]),
    .lr       (lr),
    .vec_out  (vec_out),
    .len_out  (len_out),
    .truth    (truth),
    .div_zero (div_zero)
  );

  // Track transfers through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  assign done = vld[LAT-1];

endmodule

`default_nettype wire
